// ----- rtl/pefe_pkg.sv -----
`default_nettype none
package pefe_pkg;

  // printer bytes
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] FF_BYTE   = 8'h0C;
  localparam logic [7:0] CONV_BASE = 8'hA0;

  // font codes
  localparam logic [7:0] FONT_BOLD      = 8'h62;  // b
  localparam logic [7:0] FONT_EMPH      = 8'h65;  // e
  localparam logic [7:0] FONT_UNDERLINE = 8'h75;  // u
  localparam logic [7:0] FONT_ITALIC    = 8'h69;  // i
  localparam logic [7:0] FONT_GRAPHIC   = 8'h67;  // g
  localparam logic [7:0] FONT_RESET     = 8'h6E;  // n
  localparam logic [7:0] FONT_JOB_START = 8'h0A;  // not a font, forces the next on string

  // configuration register indexes
  localparam logic [1:0] CFG_PRINTER_TYPE = 2'd0;
  localparam logic [1:0] CFG_CONVERT      = 2'd1;
  localparam logic [1:0] CFG_FORMFEED     = 2'd2;

  localparam logic [2:0] ROW_PLAIN = 3'd4;

  typedef enum logic [1:0] {
    MODE_JOB_START = 2'd0,
    MODE_CHAR      = 2'd1,
    MODE_PAGE      = 2'd2,
    MODE_JOB_END   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG_A,
    ST_SEG_B,
    ST_TAIL
  } state_e;

  typedef enum logic [1:0] {
    SEG_A,
    SEG_B,
    SEG_TAIL
  } seg_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_FF
  } tail_e;

  // string slots of an escape table row
  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_BOLD_ON  = 3'd0;
  localparam slot_t SLOT_BOLD_OFF = 3'd1;
  localparam slot_t SLOT_UL_ON    = 3'd2;
  localparam slot_t SLOT_UL_OFF   = 3'd3;
  localparam slot_t SLOT_IT_ON    = 3'd4;
  localparam slot_t SLOT_IT_OFF   = 3'd5;
  localparam slot_t SLOT_PROLOGUE = 3'd6;
  localparam slot_t SLOT_EPILOGUE = 3'd7;

  // escape string, byte 0 first, escape byte included
  typedef struct packed {
    logic [2:0]      len;
    logic [4:0][7:0] data;
  } str_t;

  typedef struct packed {
    logic       load;
    seg_e       sel;
    logic [2:0] idx;
    logic       emit;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] len_a;
    logic [2:0] len_b;
    logic       tail_en;
  } dp_stat_t;

  localparam logic [7:0] GLYPH_KEYS [12] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h7C, 8'h2A
  };
  localparam logic [7:0] GLYPH_ASCII [12] = '{
    8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2D, 8'h7C, 8'h2A
  };
  localparam logic [7:0] GLYPH_BOX [12] = '{
    8'hC0, 8'hC1, 8'hD9, 8'hC3, 8'hC5, 8'hB4, 8'hDA, 8'hC2, 8'hBF, 8'hC4, 8'hB3, 8'hF9
  };

  localparam logic [7:0] LATIN_PC8 [96] = '{
    8'h20, 8'hAD, 8'h9B, 8'h9C, 8'h2A, 8'h9D, 8'h7C, 8'hF5,
    8'h22, 8'hE9, 8'hA6, 8'hAE, 8'hAA, 8'h2D, 8'h52, 8'h7E,
    8'hF8, 8'hF1, 8'hFD, 8'h33, 8'h27, 8'hE6, 8'hF4, 8'hF9,
    8'h2C, 8'h31, 8'hA7, 8'hAF, 8'hAC, 8'hAB, 8'h33, 8'hA8,
    8'h41, 8'h41, 8'h41, 8'h41, 8'h8E, 8'h8F, 8'h92, 8'h80,
    8'h45, 8'h90, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
    8'h44, 8'hA5, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h99, 8'h78,
    8'h4F, 8'h55, 8'h55, 8'h55, 8'h9A, 8'h59, 8'hE8, 8'hE1,
    8'h85, 8'hA0, 8'h83, 8'h61, 8'h84, 8'h86, 8'h91, 8'h87,
    8'h8A, 8'h82, 8'h88, 8'h89, 8'h8D, 8'hA1, 8'h8C, 8'h8B,
    8'hEB, 8'hA4, 8'h95, 8'hA2, 8'h93, 8'h6F, 8'h94, 8'hF6,
    8'h6F, 8'h97, 8'hA3, 8'h97, 8'h81, 8'h79, 8'hE7, 8'h79
  };

  // escape string rom, rows 0 and 2 share the dot matrix set
  function automatic str_t str_rom(input logic [2:0] row, input slot_t slot);
    str_t s;
    s = '0;
    case (row)
      3'd0, 3'd2: begin
        case (slot)
          SLOT_BOLD_ON:  s = '{len: 3'd2, data: {24'h0, 8'h45, ESC_BYTE}};
          SLOT_BOLD_OFF: s = '{len: 3'd2, data: {24'h0, 8'h46, ESC_BYTE}};
          SLOT_UL_ON:    s = '{len: 3'd3, data: {16'h0, 8'h31, 8'h2D, ESC_BYTE}};
          SLOT_UL_OFF:   s = '{len: 3'd3, data: {16'h0, 8'h30, 8'h2D, ESC_BYTE}};
          SLOT_IT_ON:    s = '{len: 3'd2, data: {24'h0, 8'h34, ESC_BYTE}};
          SLOT_IT_OFF:   s = '{len: 3'd2, data: {24'h0, 8'h35, ESC_BYTE}};
          default:       s = '0;
        endcase
      end
      3'd1: begin
        case (slot)
          SLOT_BOLD_ON:  s = '{len: 3'd2, data: {24'h0, 8'h45, ESC_BYTE}};
          SLOT_BOLD_OFF: s = '{len: 3'd2, data: {24'h0, 8'h46, ESC_BYTE}};
          SLOT_UL_ON:    s = '{len: 3'd3, data: {16'h0, 8'h31, 8'h2D, ESC_BYTE}};
          SLOT_UL_OFF:   s = '{len: 3'd3, data: {16'h0, 8'h30, 8'h2D, ESC_BYTE}};
          SLOT_IT_ON:    s = '{len: 3'd2, data: {24'h0, 8'h34, ESC_BYTE}};
          SLOT_IT_OFF:   s = '{len: 3'd2, data: {24'h0, 8'h35, ESC_BYTE}};
          SLOT_PROLOGUE: s = '{len: 3'd3, data: {16'h0, 8'h31, 8'h74, ESC_BYTE}};
          SLOT_EPILOGUE: s = '{len: 3'd3, data: {16'h0, 8'h30, 8'h74, ESC_BYTE}};
          default:       s = '0;
        endcase
      end
      3'd3: begin
        case (slot)
          SLOT_BOLD_ON:  s = '{len: 3'd5, data: {8'h42, 8'h33, 8'h73, 8'h28, ESC_BYTE}};
          SLOT_BOLD_OFF: s = '{len: 3'd5, data: {8'h42, 8'h30, 8'h73, 8'h28, ESC_BYTE}};
          SLOT_UL_ON:    s = '{len: 3'd5, data: {8'h44, 8'h31, 8'h64, 8'h26, ESC_BYTE}};
          SLOT_UL_OFF:   s = '{len: 3'd4, data: {8'h00, 8'h40, 8'h64, 8'h26, ESC_BYTE}};
          SLOT_IT_ON:    s = '{len: 3'd5, data: {8'h53, 8'h31, 8'h73, 8'h28, ESC_BYTE}};
          SLOT_IT_OFF:   s = '{len: 3'd5, data: {8'h53, 8'h30, 8'h73, 8'h28, ESC_BYTE}};
          SLOT_PROLOGUE: s = '{len: 3'd5, data: {8'h55, 8'h30, 8'h31, 8'h28, ESC_BYTE}};
          default:       s = '0;
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  // on string slot of a font code, valid low for normal
  function automatic logic [3:0] font_on_slot(input logic [7:0] f);
    logic [3:0] r;
    r = '0;
    if (f == FONT_BOLD || f == FONT_EMPH) begin
      r = {1'b1, SLOT_BOLD_ON};
    end else if (f == FONT_UNDERLINE) begin
      r = {1'b1, SLOT_UL_ON};
    end else if (f == FONT_ITALIC) begin
      r = {1'b1, SLOT_IT_ON};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pefe_ctrl.sv -----
`default_nettype none
module pefe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire pefe_pkg::dp_stat_t stat_i,
  output pefe_pkg::dp_cmd_t      cmd_o
);
  import pefe_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       can_emit;
  logic       end_a, end_b;

  assign can_emit = !out_valid_q || out_ready_i;
  assign end_a    = (idx_q == stat_i.len_a - 3'd1);
  assign end_b    = (idx_q == stat_i.len_b - 3'd1);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.sel  = SEG_A;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEG_A;
          idx_d      = '0;
        end
      end
      ST_SEG_A: begin
        cmd_o.sel = SEG_A;
        if (stat_i.len_a == 3'd0) begin
          state_d = ST_SEG_B;
        end else if (can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = end_a && (stat_i.len_b == 3'd0) && !stat_i.tail_en;
          if (end_a) begin
            state_d = ST_SEG_B;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      ST_SEG_B: begin
        cmd_o.sel = SEG_B;
        if (stat_i.len_b == 3'd0) begin
          state_d = ST_TAIL;
        end else if (can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = end_b && !stat_i.tail_en;
          if (end_b) begin
            state_d = ST_TAIL;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      ST_TAIL: begin
        cmd_o.sel = SEG_TAIL;
        if (!stat_i.tail_en) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pefe_dp.sv -----
`default_nettype none
module pefe_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [2:0]        cfg_wdata_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [7:0]        font_i,
  input  wire logic [7:0]        char_in_i,
  input  wire pefe_pkg::dp_cmd_t cmd_i,
  output pefe_pkg::dp_stat_t     stat_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o
);
  import pefe_pkg::*;

  logic [2:0] printer_type_q;
  logic       convert_q;
  logic       formfeed_q;
  logic [7:0] cur_font_q, cur_font_d;

  logic       seg_a_vld_q, seg_a_vld_d;
  slot_t      seg_a_q, seg_a_d;
  logic       seg_b_vld_q, seg_b_vld_d;
  slot_t      seg_b_q, seg_b_d;
  tail_e      tail_q, tail_d;
  logic [7:0] char_q, char_d;

  logic [7:0] out_byte_q, out_byte_d;
  logic       last_q;

  logic [2:0] row;
  logic       box_row;
  logic [3:0] old_slot, new_slot;
  logic       glyph_hit;
  logic [7:0] glyph_byte;
  logic [6:0] latin_idx;
  str_t       rom_a, rom_b;

  assign row     = (printer_type_q > ROW_PLAIN) ? ROW_PLAIN : printer_type_q;
  assign box_row = (row != 3'd0) && (row != ROW_PLAIN);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      printer_type_q <= '0;
      convert_q      <= 1'b0;
      formfeed_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRINTER_TYPE: printer_type_q <= cfg_wdata_i;
        CFG_CONVERT:      convert_q      <= cfg_wdata_i[0];
        CFG_FORMFEED:     formfeed_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // graphic glyph match, keys are unique
  always_comb begin
    glyph_hit  = 1'b0;
    glyph_byte = char_in_i;
    for (int k = 0; k < 12; k++) begin
      if (char_in_i == GLYPH_KEYS[k]) begin
        glyph_hit  = 1'b1;
        glyph_byte = box_row ? GLYPH_BOX[k] : GLYPH_ASCII[k];
      end
    end
  end

  assign latin_idx = 7'(char_in_i - CONV_BASE);
  assign old_slot  = font_on_slot(cur_font_q);
  assign new_slot  = font_on_slot(font_i);

  // item decode into segment plan
  always_comb begin
    cur_font_d  = cur_font_q;
    seg_a_vld_d = seg_a_vld_q;
    seg_a_d     = seg_a_q;
    seg_b_vld_d = seg_b_vld_q;
    seg_b_d     = seg_b_q;
    tail_d      = tail_q;
    char_d      = char_q;
    if (cmd_i.load) begin
      seg_a_vld_d = 1'b0;
      seg_a_d     = SLOT_PROLOGUE;
      seg_b_vld_d = 1'b0;
      seg_b_d     = SLOT_BOLD_ON;
      tail_d      = TAIL_NONE;
      char_d      = char_in_i;
      case (mode_e'(mode_i))
        MODE_JOB_START: begin
          seg_a_vld_d = 1'b1;
          seg_a_d     = SLOT_PROLOGUE;
          cur_font_d  = FONT_JOB_START;
        end
        MODE_CHAR: begin
          if (font_i != cur_font_q) begin
            seg_a_vld_d = old_slot[3];
            seg_a_d     = old_slot[2:0] + 3'd1;
            seg_b_vld_d = new_slot[3];
            seg_b_d     = new_slot[2:0];
            cur_font_d  = font_i;
          end
          tail_d = TAIL_CHAR;
          if (font_i == FONT_GRAPHIC) begin
            char_d = glyph_hit ? glyph_byte : char_in_i;
          end else if (convert_q && char_in_i >= CONV_BASE) begin
            char_d = LATIN_PC8[latin_idx];
          end
        end
        MODE_PAGE: begin
          tail_d = TAIL_FF;
        end
        MODE_JOB_END: begin
          seg_a_vld_d = 1'b1;
          seg_a_d     = SLOT_EPILOGUE;
          tail_d      = formfeed_q ? TAIL_FF : TAIL_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_font_q  <= FONT_RESET;
      seg_a_vld_q <= 1'b0;
      seg_b_vld_q <= 1'b0;
      tail_q      <= TAIL_NONE;
    end else begin
      cur_font_q  <= cur_font_d;
      seg_a_vld_q <= seg_a_vld_d;
      seg_b_vld_q <= seg_b_vld_d;
      tail_q      <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_a_q <= seg_a_d;
    seg_b_q <= seg_b_d;
    char_q  <= char_d;
  end

  assign rom_a = str_rom(row, seg_a_q);
  assign rom_b = str_rom(row, seg_b_q);

  assign stat_o.len_a   = seg_a_vld_q ? rom_a.len : 3'd0;
  assign stat_o.len_b   = seg_b_vld_q ? rom_b.len : 3'd0;
  assign stat_o.tail_en = (tail_q != TAIL_NONE);

  // byte select
  always_comb begin
    case (cmd_i.sel)
      SEG_A:    out_byte_d = rom_a.data[cmd_i.idx];
      SEG_B:    out_byte_d = rom_b.data[cmd_i.idx];
      SEG_TAIL: out_byte_d = (tail_q == TAIL_FF) ? FF_BYTE : char_q;
      default:  out_byte_d = char_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= out_byte_d;
      last_q     <= cmd_i.last;
    end
  end

  assign out_byte_o = out_byte_q;
  assign last_o     = last_q;

endmodule
`default_nettype wire

// ----- rtl/printer_escape_font_encoder.sv -----
`default_nettype none
// printer escape font encoder: turns job start, character, page break and job end
// events into a stream of printer bytes, one byte per output word, with last_o high on
// the final byte of each event. an event that produces nothing (a job start or job end
// on a printer row without a prologue or epilogue and no formfeed) gives no word at all.
// each event runs in_ready_o low after acceptance and walks three segments: an old-font
// off string (or prologue/epilogue), a new-font on string, then the character or
// formfeed. the two escape strings are 0 to 5 bytes long. the byte sequencer in the
// controller walks the segments and holds while the output side stalls, and it takes
// a new event only after the last one has walked all its segments.
// configuration registers (printer_type, convert_enable, formfeed_enable) are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while no event is in
// flight. printer_type values above 4 act as the plain printer row with no escapes.
module printer_escape_font_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [2:0] cfg_wdata_i,
  // event input
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] font_i,
  input  wire logic [7:0] char_in_i,
  // printer byte output
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import pefe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: walks the segments and owns the output word valid
  pefe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config, current font, escape rom, character remap and output register
  pefe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .font_i      (font_i),
    .char_in_i   (char_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ----- rtl/pefe_chk.sv -----
`default_nettype none
module pefe_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_o
);

  // an accepted event closes the input in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted event");

  // a pending word that is not last means the event is still running
  a_no_accept_mid_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open while an event still has bytes to send");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // valid only drops after a taken word
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output valid dropped without a transfer");

endmodule

bind printer_escape_font_encoder pefe_chk u_pefe_chk (.*);
`default_nettype wire

// ----- verif/tb_printer_escape_font_encoder.sv -----
`timescale 1ns / 1ps

module tb_printer_escape_font_encoder;
  import pefe_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // long output hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // quiet time before a register write, covers an event that emits nothing
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_EVENTS = 33;

  // register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // printer rows with their own escape strings
  localparam logic [2:0] PT_DOT     = 3'd0;  // dot matrix, ascii glyphs
  localparam logic [2:0] PT_DOT_JOB = 3'd1;  // dot matrix with job strings
  localparam logic [2:0] PT_LASER   = 3'd3;  // laser, long escapes

  // graphic font keys and their two replacement sets
  localparam logic [7:0] KEY_TAB [12] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h7C, 8'h2A
  };
  localparam logic [7:0] ASCII_TAB [12] = '{
    8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2B, 8'h2D, 8'h7C, 8'h2A
  };
  localparam logic [7:0] BOX_TAB [12] = '{
    8'hC0, 8'hC1, 8'hD9, 8'hC3, 8'hC5, 8'hB4, 8'hDA, 8'hC2, 8'hBF, 8'hC4, 8'hB3, 8'hF9
  };

  // latin-1 0xa0..0xff to pc-8
  localparam logic [7:0] PC8_TAB [96] = '{
    8'h20, 8'hAD, 8'h9B, 8'h9C, 8'h2A, 8'h9D, 8'h7C, 8'hF5,
    8'h22, 8'hE9, 8'hA6, 8'hAE, 8'hAA, 8'h2D, 8'h52, 8'h7E,
    8'hF8, 8'hF1, 8'hFD, 8'h33, 8'h27, 8'hE6, 8'hF4, 8'hF9,
    8'h2C, 8'h31, 8'hA7, 8'hAF, 8'hAC, 8'hAB, 8'h33, 8'hA8,
    8'h41, 8'h41, 8'h41, 8'h41, 8'h8E, 8'h8F, 8'h92, 8'h80,
    8'h45, 8'h90, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
    8'h44, 8'hA5, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h99, 8'h78,
    8'h4F, 8'h55, 8'h55, 8'h55, 8'h9A, 8'h59, 8'hE8, 8'hE1,
    8'h85, 8'hA0, 8'h83, 8'h61, 8'h84, 8'h86, 8'h91, 8'h87,
    8'h8A, 8'h82, 8'h88, 8'h89, 8'h8D, 8'hA1, 8'h8C, 8'h8B,
    8'hEB, 8'hA4, 8'h95, 8'hA2, 8'h93, 8'h6F, 8'h94, 8'hF6,
    8'h6F, 8'h97, 8'hA3, 8'h97, 8'h81, 8'h79, 8'hE7, 8'h79
  };

  typedef struct packed {
    mode_e      mode;
    logic [7:0] font;
    logic [7:0] ch;
  } ev_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } pbyte_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_PRINTER_TYPE;
  logic [2:0] cfg_wdata_i = 3'd0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] mode_i      = MODE_JOB_START;
  logic [7:0] font_i      = 8'd0;
  logic [7:0] char_in_i   = 8'd0;
  logic       out_ready_i = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  printer_escape_font_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .font_i      (font_i),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // encoder shadow: font state and register copies
  logic [7:0] font_now = FONT_RESET;
  logic [2:0] pt_reg   = 3'd0;
  logic       conv_reg = 1'b0;
  logic       ff_reg   = 1'b0;

  ev_item_t   pending[$];        // events waiting for the driver
  pbyte_t     printer_bytes[$];  // printer bytes still owed by the block
  logic [7:0] word_buf[$];       // bytes of the event being encoded

  // driver and receiver bookkeeping
  ev_item_t cur_ev;
  logic     cur_loaded = 1'b0;
  logic     in_taken   = 1'b0;
  logic     out_taken  = 1'b0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       tx_mode = 0;
  int       rx_mode = 0;
  logic     hold_start = 1'b0;
  int       hold_left = 0;

  int cycles = 0;
  int items_in = 0;
  int words_out = 0;
  int mismatches = 0;
  int cfg_sets = 0;

  // escape text after the esc byte, empty when the row has none
  function automatic string esc_tail(input logic [2:0] row, input slot_t slot);
    string t;
    t = "";
    if (row == PT_LASER) begin
      case (slot)
        SLOT_BOLD_ON:  t = "(s3B";
        SLOT_BOLD_OFF: t = "(s0B";
        SLOT_UL_ON:    t = "&d1D";
        SLOT_UL_OFF:   t = "&d@";
        SLOT_IT_ON:    t = "(s1S";
        SLOT_IT_OFF:   t = "(s0S";
        SLOT_PROLOGUE: t = "(10U";
        default:       t = "";
      endcase
    end else if (row != ROW_PLAIN) begin
      case (slot)
        SLOT_BOLD_ON:  t = "E";
        SLOT_BOLD_OFF: t = "F";
        SLOT_UL_ON:    t = "-1";
        SLOT_UL_OFF:   t = "-0";
        SLOT_IT_ON:    t = "4";
        SLOT_IT_OFF:   t = "5";
        SLOT_PROLOGUE: t = (row == PT_DOT_JOB) ? "t1" : "";
        SLOT_EPILOGUE: t = (row == PT_DOT_JOB) ? "t0" : "";
        default:       t = "";
      endcase
    end
    return t;
  endfunction

  // on string slot of a font code, -1 for a normal font
  function automatic int on_slot(input logic [7:0] f);
    if (f == FONT_BOLD || f == FONT_EMPH) return int'(SLOT_BOLD_ON);
    if (f == FONT_UNDERLINE) return int'(SLOT_UL_ON);
    if (f == FONT_ITALIC) return int'(SLOT_IT_ON);
    return -1;
  endfunction

  task automatic add_escape(input logic [2:0] row, input slot_t slot);
    string t;
    int k;
    t = esc_tail(row, slot);
    if (t.len() > 0) begin
      word_buf.push_back(ESC_BYTE);
      for (k = 0; k < t.len(); k++) word_buf.push_back(t[k]);
    end
  endtask

  // work out the printer bytes of one event and queue them
  task automatic encode_event(input ev_item_t ev);
    logic [2:0] row;
    logic [7:0] c;
    pbyte_t     w;
    int         s;
    int         k;
    logic       hit;
    row = (pt_reg > ROW_PLAIN) ? ROW_PLAIN : pt_reg;
    word_buf.delete();
    case (ev.mode)
      MODE_JOB_START: begin
        add_escape(row, SLOT_PROLOGUE);
        font_now = FONT_JOB_START;
      end
      MODE_CHAR: begin
        if (ev.font != font_now) begin
          s = on_slot(font_now);
          if (s >= 0) add_escape(row, slot_t'(s + 1));
          s = on_slot(ev.font);
          if (s >= 0) add_escape(row, slot_t'(s));
          font_now = ev.font;
        end
        c = ev.ch;
        hit = 1'b0;
        if (ev.font == FONT_GRAPHIC) begin
          // graphic glyphs: ascii art on row 0 and the plain row, box drawing elsewhere
          for (k = 0; k < 12; k++) begin
            if (!hit && c == KEY_TAB[k]) begin
              c = (row == PT_DOT || row == ROW_PLAIN) ? ASCII_TAB[k] : BOX_TAB[k];
              hit = 1'b1;
            end
          end
        end else if (conv_reg && c >= CONV_BASE) begin
          c = PC8_TAB[c - CONV_BASE];
        end
        word_buf.push_back(c);
      end
      MODE_PAGE: word_buf.push_back(FF_BYTE);
      default: begin
        add_escape(row, SLOT_EPILOGUE);
        if (ff_reg) word_buf.push_back(FF_BYTE);
      end
    endcase
    for (k = 0; k < word_buf.size(); k++) begin
      w.b = word_buf[k];
      w.last = (k == word_buf.size() - 1);
      printer_bytes.push_back(w);
    end
  endtask

  function automatic int draw_gap(input int gap_mode);
    case (gap_mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  // input driver: payload and valid change on the falling edge
  always @(negedge clk_i) begin : input_driver
    logic nv;
    nv = in_valid_i;
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        nv = 1'b0;
        tx_gap = draw_gap(tx_mode);
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() > 0) begin
          cur_ev = pending.pop_front();
          cur_loaded = 1'b1;
          nv = 1'b1;
          mode_i <= cur_ev.mode;
          font_i <= cur_ev.font;
          char_in_i <= cur_ev.ch;
        end
      end
    end
    // one assignment per step, a back to back word keeps valid high
    in_valid_i <= nv;
  end

  // input acceptance: predict as the word is taken
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      encode_event(cur_ev);
      cur_loaded = 1'b0;
      in_taken = 1'b1;
      items_in++;
    end
  end

  // receiver ready, per word stalls plus the long hold-off
  always @(negedge clk_i) begin : output_ready
    logic nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        rx_gap = draw_gap(rx_mode);
      end
      if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        nr = (hold_left == 0);
      end
    end
    out_ready_i <= nr;
  end

  // hold-off counter lives on its own, counted on the rising edge
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // output monitor: compare each word with the oldest owed byte
  always @(posedge clk_i) begin : output_monitor
    pbyte_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      words_out++;
      if (printer_bytes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: byte %h last %b", out_byte_o, last_o);
        mismatches++;
      end else begin
        w = printer_bytes.pop_front();
        if (out_byte_o !== w.b || last_o !== w.last) begin
          if (mismatches < 10)
            $display("mismatch at word %0d: expected byte %h last %b, got byte %h last %b",
                     words_out, w.b, w.last, out_byte_o, last_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles,
               printer_bytes.size());
      $display("tb_printer_escape_font_encoder NOT OK");
      $finish;
    end
  end

  task automatic put_ev(input mode_e m, input logic [7:0] f, input logic [7:0] c);
    ev_item_t ev;
    ev.mode = m;
    ev.font = f;
    ev.ch = c;
    pending.push_back(ev);
  endtask

  // wait until every event went in and every byte came out, then settle
  task automatic drain();
    while (pending.size() != 0 || cur_loaded || printer_bytes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write on the falling edge, shadow copy follows the field width
  // after each write the enable goes low and stays low until the task returns
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PRINTER_TYPE: pt_reg = val;
      CFG_CONVERT:      conv_reg = val[0];
      CFG_FORMFEED:     ff_reg = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] pt, input logic conv, input logic ff);
    write_reg(CFG_PRINTER_TYPE, pt);
    // upper data bits are don't care for the one bit registers
    write_reg(CFG_CONVERT, {2'($urandom_range(0, 3)), conv});
    write_reg(CFG_FORMFEED, {2'($urandom_range(0, 3)), ff});
    cfg_sets++;
  endtask

  function automatic logic [7:0] pick_font();
    case ($urandom_range(0, 9))
      0:       return FONT_BOLD;
      1:       return FONT_EMPH;
      2:       return FONT_UNDERLINE;
      3:       return FONT_ITALIC;
      4, 5:    return FONT_GRAPHIC;
      6:       return FONT_RESET;
      7:       return FONT_JOB_START;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_char(input logic [7:0] f);
    if (f == FONT_GRAPHIC && $urandom_range(0, 1) == 1)
      return KEY_TAB[$urandom_range(0, 11)];
    if ($urandom_range(0, 2) == 0)
      return 8'($urandom_range(160, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int p;
    int n;
    int k;
    logic [7:0] run_font;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset registers: dot matrix row, no conversion, no formfeed
    tx_mode = 0;
    rx_mode = 2;
    put_ev(MODE_CHAR, FONT_RESET, 8'h41);     // reset font needs no escape
    put_ev(MODE_CHAR, FONT_BOLD, 8'h00);      // bold on, zero byte
    put_ev(MODE_CHAR, FONT_BOLD, 8'hFF);      // high byte, conversion off
    put_ev(MODE_CHAR, FONT_GRAPHIC, 8'h31);   // bold off, glyph as ascii
    put_ev(MODE_CHAR, FONT_GRAPHIC, 8'h2A);
    put_ev(MODE_CHAR, FONT_GRAPHIC, 8'h41);   // non glyph passes
    put_ev(MODE_CHAR, FONT_UNDERLINE, 8'hA0);
    put_ev(MODE_JOB_START, 8'hFF, 8'hFF);     // nothing to send here
    put_ev(MODE_CHAR, FONT_JOB_START, 8'h7A); // same code as job start font
    put_ev(MODE_JOB_END, 8'h00, 8'h00);       // nothing to send either
    put_ev(MODE_PAGE, 8'hAA, 8'h55);
    put_ev(MODE_CHAR, FONT_ITALIC, 8'h7F);
    drain();

    // directed, laser row with conversion and formfeed
    set_config(PT_LASER, 1'b1, 1'b1);
    put_ev(MODE_JOB_START, 8'h00, 8'h00);     // prologue
    put_ev(MODE_CHAR, FONT_UNDERLINE, 8'hFF); // from job start font, converted
    put_ev(MODE_CHAR, FONT_ITALIC, 8'hA0);    // short off string then on
    put_ev(MODE_CHAR, FONT_BOLD, 8'hA5);      // longest font change
    put_ev(MODE_CHAR, FONT_EMPH, 8'h78);      // bold to emphasized still changes
    put_ev(MODE_CHAR, FONT_GRAPHIC, 8'h35);   // box glyph
    put_ev(MODE_CHAR, FONT_GRAPHIC, 8'hA5);   // graphic font is never converted
    put_ev(MODE_CHAR, 8'hFF, 8'hFF);          // odd font code is normal
    put_ev(MODE_PAGE, 8'h00, 8'h00);
    put_ev(MODE_JOB_END, 8'h00, 8'h00);       // no epilogue, formfeed only
    drain();

    // directed, row with job strings
    set_config(PT_DOT_JOB, 1'b0, 1'b0);
    put_ev(MODE_JOB_START, 8'h55, 8'hAA);
    put_ev(MODE_CHAR, FONT_UNDERLINE, 8'h2D);
    put_ev(MODE_JOB_END, 8'hFF, 8'hFF);
    drain();

    // random phases, every printer type, both flag values
    for (p = 0; p < RAND_PHASES; p++) begin
      set_config((p < 8) ? 3'(p) : 3'($urandom_range(0, 7)), p[0], p[1]);
      // the unused register index must leave everything alone
      write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
      tx_mode = p % 3;
      rx_mode = (p + 1) % 3;
      if (p == 5) begin
        tx_mode = 0;
        rx_mode = 0;
      end
      if (p == 3) begin
        // receiver holds off while the sender keeps offering
        tx_mode = 0;
        hold_start = 1'b1;
      end
      n = 0;
      while (n < PHASE_EVENTS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any mode, any payload
          put_ev(mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
          n++;
        end else begin
          // a job: start, characters in runs of fonts, page breaks, and an end in most jobs
          put_ev(MODE_JOB_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          run_font = pick_font();
          for (k = $urandom_range(1, 8); k > 0; k--) begin
            if ($urandom_range(0, 3) == 0) run_font = pick_font();
            if ($urandom_range(0, 9) == 0)
              put_ev(MODE_PAGE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
              put_ev(MODE_CHAR, run_font, pick_char(run_font));
            n++;
          end
          if ($urandom_range(0, 5) != 0)
            put_ev(MODE_JOB_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          n += 2;
        end
      end
      drain();
    end

    $display("covered %0d events and %0d printer bytes over %0d register settings,",
             items_in, words_out, cfg_sets);
    $display("all printer types and flags, random stalls and one long output hold-off");
    if (mismatches == 0 && printer_bytes.size() == 0) begin
      $display("tb_printer_escape_font_encoder OK");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", mismatches, printer_bytes.size());
      $display("tb_printer_escape_font_encoder NOT OK");
    end
    $finish;
  end

endmodule
